### src/u8cp_pkg.sv
// ============================================================================
// u8cp_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ============================================================================
`default_nettype none

package u8cp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned PAYLOAD_W = 6;

    // Lead byte class masks and match patterns.
    localparam logic [BYTE_W-1:0] MASK_2B  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_2B  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_3B  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_3B  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_4B  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_4B  = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_5B  = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD_5B  = 8'hF8;
    localparam logic [BYTE_W-1:0] MASK_6B  = 8'hFE;
    localparam logic [BYTE_W-1:0] LEAD_6B  = 8'hFC;

    // Payload masks of the lead classes.
    localparam logic [BYTE_W-1:0] DATA_2B  = 8'h1F;
    localparam logic [BYTE_W-1:0] DATA_3B  = 8'h0F;
    localparam logic [BYTE_W-1:0] DATA_4B  = 8'h07;
    localparam logic [BYTE_W-1:0] DATA_5B  = 8'h03;
    localparam logic [BYTE_W-1:0] DATA_6B  = 8'h01;

    // Pending continuation counts opened by each lead class.
    localparam logic [PEND_W-1:0] PEND_NONE = 3'd0;
    localparam logic [PEND_W-1:0] PEND_2B   = 3'd1;
    localparam logic [PEND_W-1:0] PEND_3B   = 3'd2;
    localparam logic [PEND_W-1:0] PEND_4B   = 3'd3;
    localparam logic [PEND_W-1:0] PEND_5B   = 3'd4;
    localparam logic [PEND_W-1:0] PEND_6B   = 3'd5;

    // Sequence state carried from one byte to the next.
    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [CP_W-1:0]   partial;
    } t_seq_state;

    // Outcome of decoding one byte.
    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic              lead_invalid;
        t_seq_state        next_state;
    } t_step_out;

endpackage

`default_nettype wire

### src/u8cp_step.sv
// ============================================================================
// u8cp_step
// Decodes one byte against the current sequence state.
// ============================================================================
`default_nettype none

module u8cp_step (
    input  wire logic [u8cp_pkg::BYTE_W-1:0] i_byte,
    input  wire u8cp_pkg::t_seq_state        i_state,
    output u8cp_pkg::t_step_out              o_step
);

    logic [u8cp_pkg::CP_W-1:0]   shifted;
    logic [u8cp_pkg::PEND_W-1:0] pend_dec;

    // Continuation bytes contribute their low six bits; the marker is ignored.
    assign shifted  = {i_state.partial[u8cp_pkg::CP_W-u8cp_pkg::PAYLOAD_W-1:0],
                       i_byte[u8cp_pkg::PAYLOAD_W-1:0]};
    assign pend_dec = i_state.pending - u8cp_pkg::PEND_W'(1);

    always_comb begin
        o_step                    = '0;
        o_step.next_state         = i_state;
        if (i_state.pending != u8cp_pkg::PEND_NONE) begin
            if (pend_dec == u8cp_pkg::PEND_NONE) begin
                o_step.emit       = 1'b1;
                o_step.code_point = shifted;
                o_step.next_state = '0;
            end else begin
                o_step.next_state.pending = pend_dec;
                o_step.next_state.partial = shifted;
            end
        end else if (!i_byte[u8cp_pkg::BYTE_W-1]) begin
            o_step.emit       = 1'b1;
            o_step.code_point = u8cp_pkg::CP_W'(i_byte);
        end else if ((i_byte & u8cp_pkg::MASK_2B) == u8cp_pkg::LEAD_2B) begin
            o_step.next_state.pending = u8cp_pkg::PEND_2B;
            o_step.next_state.partial = u8cp_pkg::CP_W'(i_byte & u8cp_pkg::DATA_2B);
        end else if ((i_byte & u8cp_pkg::MASK_3B) == u8cp_pkg::LEAD_3B) begin
            o_step.next_state.pending = u8cp_pkg::PEND_3B;
            o_step.next_state.partial = u8cp_pkg::CP_W'(i_byte & u8cp_pkg::DATA_3B);
        end else if ((i_byte & u8cp_pkg::MASK_4B) == u8cp_pkg::LEAD_4B) begin
            o_step.next_state.pending = u8cp_pkg::PEND_4B;
            o_step.next_state.partial = u8cp_pkg::CP_W'(i_byte & u8cp_pkg::DATA_4B);
        end else if ((i_byte & u8cp_pkg::MASK_5B) == u8cp_pkg::LEAD_5B) begin
            o_step.next_state.pending = u8cp_pkg::PEND_5B;
            o_step.next_state.partial = u8cp_pkg::CP_W'(i_byte & u8cp_pkg::DATA_5B);
        end else if ((i_byte & u8cp_pkg::MASK_6B) == u8cp_pkg::LEAD_6B) begin
            o_step.next_state.pending = u8cp_pkg::PEND_6B;
            o_step.next_state.partial = u8cp_pkg::CP_W'(i_byte & u8cp_pkg::DATA_6B);
        end else begin
            // Stray continuation byte, 0xFE or 0xFF where a lead was expected.
            o_step.emit         = 1'b1;
            o_step.lead_invalid = 1'b1;
        end
    end

endmodule

`default_nettype wire

### src/utf8_to_codepoint_decoder_core.sv
// A byte that completes a sequence shows its code point from the result register.
// Throughput: one byte per cycle unless the output stalls, set by the single decode step.
// Bytes that only open or extend a sequence produce no result item.
// Reset (synchronous, active low) empties both registers and closes any open sequence.
// ============================================================================
// utf8_to_codepoint_decoder_core
// Streaming UTF-8 decoder that accepts the legacy 1- to 6-byte forms.
// ============================================================================
`default_nettype none

module utf8_to_codepoint_decoder_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [u8cp_pkg::BYTE_W-1:0] i_in_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [u8cp_pkg::CP_W-1:0]        o_code_point,
    output logic                             o_lead_invalid
);

    // Input register: holds the accepted byte until the decode step consumes it.
    logic                         r_in_valid;
    logic [u8cp_pkg::BYTE_W-1:0]  r_in_byte;

    // Sequence state: pending continuation count and the payload gathered so far.
    u8cp_pkg::t_seq_state         r_state;

    // Result register: holds one result item until the downstream side takes it.
    logic                         r_out_valid;
    logic [u8cp_pkg::CP_W-1:0]    r_code_point;
    logic                         r_lead_invalid;

    u8cp_pkg::t_step_out          step;
    logic                         advance;
    logic                         n_out_valid;

    u8cp_step u_step (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_step  (step)
    );

    // The held byte moves through the decode step whenever the result register
    // is free or is emptied in this cycle. Bytes that give no result could
    // always move, but tying every byte to the same rule keeps the order simple
    // and still sustains one byte per cycle when the output is not stalled.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);

    // The input side is stalled only when the held byte cannot move on.
    assign o_in_stall = r_in_valid && !advance;

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance && step.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= step.next_state;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
        if (advance && step.emit) begin
            r_code_point   <= step.code_point;
            r_lead_invalid <= step.lead_invalid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_point   = r_code_point;
    assign o_lead_invalid = r_lead_invalid;

endmodule

`default_nettype wire

### src/u8cp_checker.sv
// ============================================================================
// u8cp_checker
// Port-level checks for the UTF-8 to code point decoder.
// ============================================================================
`default_nettype none

module u8cp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic [u8cp_pkg::BYTE_W-1:0] i_in_byte,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [u8cp_pkg::CP_W-1:0]   o_code_point,
    input wire logic                        o_lead_invalid
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_code_point) && $stable(o_lead_invalid))
        else $error("result item changed while stalled");

    // A stalled input item is still offered with the same byte.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_byte))
        else $error("input item changed while stalled");

    // An invalid lead always reports code point zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lead_invalid |-> o_code_point == '0)
        else $error("invalid lead with nonzero code point");

    // The input side only stalls when a result item is waiting and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // With the output free, a byte held in the decoder never blocks the next one.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the result register is empty");

endmodule

bind utf8_to_codepoint_decoder_core u8cp_checker u_u8cp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_in_byte      (i_in_byte),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_code_point   (o_code_point),
    .o_lead_invalid (o_lead_invalid)
);

`default_nettype wire
